### rtl/lease_index_allocator_assert.svh
// Assertion macros for the lease index allocator.
// Used by lease_index_allocator.sv; expects i_clk and i_rst_n in scope.
`ifndef LEASE_INDEX_ALLOCATOR_ASSERT_SVH
`define LEASE_INDEX_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define LIA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LIA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lia_pkg.sv
// Shared types, codes and constants of the lease index allocator.
// No dependencies; used by lia_keygen and lease_index_allocator.
package lia_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int SLOT_W     = 10;
    localparam int CNT_W      = 11;
    localparam int HALF_W     = 5;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [HALF_W-1:0] t_half_word;

    localparam logic [31:0] MIX_A    = 32'h9e3779b9;
    localparam logic [31:0] MIX_B    = 32'h045d9f3b;
    localparam logic [63:0] KEY_STEP = 64'h517cc1b727220a95;
    localparam logic [63:0] KEY_MUL  = 64'hbf58476d1ce4e5b9;

    localparam logic [1:0] MODE_GET     = 2'd0;
    localparam logic [1:0] MODE_MARK    = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [7:0] CFG_POOL_SIZE    = 8'd0;
    localparam logic [7:0] CFG_SHUFFLE_SEED = 8'd1;

    // half width of the Feistel split: (bit length of size-1, at least 1, + 1) / 2
    function automatic logic [2:0] half_bits(input t_count size);
        t_count     n;
        logic [3:0] b;
        n = size - t_count'(1);
        b = 4'd0;
        for (int i = 0; i < CNT_W; i++) begin
            if (n[i]) begin
                b = 4'(i + 1);
            end
        end
        if (b == 4'd0) begin
            b = 4'd1;
        end
        return 3'((b + 4'd1) >> 1);
    endfunction

endpackage

### rtl/lia_keygen.sv
// Round key derivation from the shuffle seed, one shared 32x32 multiplier.
// Depends on lia_pkg.
module lia_keygen import lia_pkg::*; #(
    parameter int ROUNDS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [63:0]            i_seed,
    output logic [ROUNDS-1:0][31:0] o_keys,
    output logic                   o_busy
);

    localparam int RND_W = $clog2(ROUNDS);

    localparam logic [2:0] K_MIX = 3'd0;
    localparam logic [2:0] K_P0  = 3'd1;
    localparam logic [2:0] K_P1  = 3'd2;
    localparam logic [2:0] K_P2  = 3'd3;
    localparam logic [2:0] K_SUM = 3'd4;

    logic                    r_run, n_run;
    logic [RND_W-1:0]        r_round, n_round;
    logic [2:0]              r_step, n_step;
    logic [63:0]             r_seed, n_seed;
    logic [63:0]             r_off, n_off;
    logic [63:0]             r_k, n_k;
    logic [63:0]             r_p0, n_p0;
    logic [31:0]             r_p1, n_p1;
    logic [31:0]             r_p2, n_p2;
    logic [ROUNDS-1:0][31:0] r_keys, n_keys;

    logic [63:0] base;
    logic [63:0] prod;
    logic [63:0] mixed;

    always_comb begin
        n_run   = r_run;
        n_round = r_round;
        n_step  = r_step;
        n_seed  = r_seed;
        n_off   = r_off;
        n_k     = r_k;
        n_p0    = r_p0;
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_keys  = r_keys;
        base    = r_seed + r_off;
        prod    = r_p0 + {r_p1 + r_p2, 32'd0};
        mixed   = prod ^ (prod >> 27);
        if (i_load) begin
            n_seed  = i_seed;
            n_off   = '0;
            n_round = '0;
            n_step  = K_MIX;
            n_run   = 1'b1;
        end else if (r_run) begin
            case (r_step)
                K_MIX: begin
                    n_k    = base ^ (base >> 30);
                    n_step = K_P0;
                end
                K_P0: begin
                    n_p0   = {32'd0, r_k[31:0]} * {32'd0, KEY_MUL[31:0]};
                    n_step = K_P1;
                end
                K_P1: begin
                    n_p1   = 32'(r_k[31:0] * KEY_MUL[63:32]);
                    n_step = K_P2;
                end
                K_P2: begin
                    n_p2   = 32'(r_k[63:32] * KEY_MUL[31:0]);
                    n_step = K_SUM;
                end
                K_SUM: begin
                    n_keys[r_round] = mixed[31:0];
                    n_step          = K_MIX;
                    if (r_round == RND_W'(ROUNDS - 1)) begin
                        n_run = 1'b0;
                    end else begin
                        n_round = r_round + RND_W'(1);
                        n_off   = r_off + KEY_STEP;
                    end
                end
                default: begin
                    n_step = K_MIX;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b1;
            r_round <= '0;
            r_step  <= K_MIX;
            r_seed  <= '0;
            r_off   <= '0;
        end else begin
            r_run   <= n_run;
            r_round <= n_round;
            r_step  <= n_step;
            r_seed  <= n_seed;
            r_off   <= n_off;
        end
        r_k    <= n_k;
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_keys <= n_keys;
    end

    assign o_keys = r_keys;
    assign o_busy = r_run;

endmodule

### rtl/lease_index_allocator.sv
// Lease index allocator: lease bitmap and free ring in memories, fill pointer, Feistel shuffle.
// Depends on lia_pkg, lia_keygen and lease_index_allocator_assert.svh.
//
//  channel   signals                                           handshake
//  command   start, i_mode, i_slot_index                       start & !busy
//  result    o_status, o_slot_out, o_leased_count              o_done, one cycle
//  config    i_cfg_index, i_cfg_data                           i_cfg_valid & o_cfg_ready
//
// Mark, release and unused mode: result in the cycle after acceptance.
// Get: fill via S_LW, S_LCHK; ring pop or retry via S_RW, S_RCHK, S_LW, S_LCHK; with a seed,
//   each Feistel pass adds S_PA, S_PB, S_PC a round and S_PX (one multiplier, two multiplies).
// After reset the lease bitmap is cleared, one entry a cycle, all 1024 entries with busy high.
// A seed write re-derives the round keys in lia_keygen; busy and !o_cfg_ready meanwhile.
// The receiver cannot stall; o_done marks each result for one cycle.
`include "lease_index_allocator_assert.svh"

module lease_index_allocator import lia_pkg::*; #(
    parameter int ROUNDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [1:0]  i_mode,
    input  logic [9:0]  i_slot_index,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [9:0]  o_slot_out,
    output logic [10:0] o_leased_count
);

    localparam int RND_W = $clog2(ROUNDS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PA   = 4'd1;
    localparam logic [3:0] S_PB   = 4'd2;
    localparam logic [3:0] S_PC   = 4'd3;
    localparam logic [3:0] S_PX   = 4'd4;
    localparam logic [3:0] S_LW   = 4'd5;
    localparam logic [3:0] S_LCHK = 4'd6;
    localparam logic [3:0] S_RW   = 4'd7;
    localparam logic [3:0] S_RCHK = 4'd8;

    logic [3:0]       r_state, n_state;
    t_count           r_pool_size, n_pool_size;
    logic             r_seed_nz, n_seed_nz;
    t_count           r_size, n_size;
    logic [2:0]       r_half, n_half;
    t_half_word       r_mask, n_mask;
    t_half_word       r_l, n_l;
    t_half_word       r_r, n_r;
    logic [RND_W-1:0] r_round, n_round;
    logic [31:0]      r_m, n_m;
    t_slot            r_cand, n_cand;
    logic             r_from_ring, n_from_ring;
    t_count           r_fill, n_fill;
    t_count           r_used, n_used;
    t_slot            r_head, n_head;
    t_slot            r_tail, n_tail;
    t_count           r_rcount, n_rcount;
    logic             r_clr, n_clr;
    t_slot            r_clr_addr, n_clr_addr;
    logic             r_done, n_done;
    logic [1:0]       r_status, n_status;
    t_slot            r_slot, n_slot;

    logic  lease_mem [POOL_DEPTH];
    t_slot ring_mem  [POOL_DEPTH];
    logic  r_lease_q;
    t_slot r_ring_q;
    logic  lease_we, lease_wd;
    t_slot lease_wa;
    logic  ring_we;

    logic [ROUNDS-1:0][31:0] keys;
    logic   key_busy;
    logic   cfg_we;
    logic   accept;
    t_count sz;
    logic [2:0] h;
    t_slot  x;
    t_slot  xs;
    logic [31:0] v;
    logic [31:0] vm;

    function automatic t_slot ring_next(input t_slot p, input t_count size);
        t_count p1;
        p1 = t_count'(p) + t_count'(1);
        return (p1 >= size) ? t_slot'(0) : p1[SLOT_W-1:0];
    endfunction

    lia_keygen #(.ROUNDS(ROUNDS)) u_keygen (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (cfg_we && i_cfg_index == CFG_SHUFFLE_SEED),
        .i_seed (i_cfg_data),
        .o_keys (keys),
        .o_busy (key_busy)
    );

    assign o_cfg_ready = !key_busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign busy        = (r_state != S_IDLE) || r_clr || key_busy;
    assign accept      = start && !busy;

    always_comb begin
        if (r_pool_size == '0) begin
            sz = t_count'(1);
        end else if (r_pool_size > t_count'(POOL_DEPTH)) begin
            sz = t_count'(POOL_DEPTH);
        end else begin
            sz = r_pool_size;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pool_size = r_pool_size;
        n_seed_nz   = r_seed_nz;
        n_size      = r_size;
        n_half      = r_half;
        n_mask      = r_mask;
        n_l         = r_l;
        n_r         = r_r;
        n_round     = r_round;
        n_m         = r_m;
        n_cand      = r_cand;
        n_from_ring = r_from_ring;
        n_fill      = r_fill;
        n_used      = r_used;
        n_head      = r_head;
        n_tail      = r_tail;
        n_rcount    = r_rcount;
        n_clr       = r_clr;
        n_clr_addr  = r_clr_addr;
        n_done      = 1'b0;
        n_status    = r_status;
        n_slot      = r_slot;
        lease_we    = 1'b0;
        lease_wa    = r_cand;
        lease_wd    = 1'b0;
        ring_we     = 1'b0;
        h           = half_bits(sz);
        x           = r_fill[SLOT_W-1:0];
        xs          = x >> h;
        v           = {{(32-HALF_W){1'b0}}, r_r} ^ keys[r_round];
        vm          = r_m ^ (r_m >> 16);

        if (cfg_we) begin
            if (i_cfg_index == CFG_POOL_SIZE) begin
                n_pool_size = i_cfg_data[CNT_W-1:0];
            end else if (i_cfg_index == CFG_SHUFFLE_SEED) begin
                n_seed_nz = |i_cfg_data;
            end
        end

        if (r_clr) begin
            lease_we   = 1'b1;
            lease_wa   = r_clr_addr;
            lease_wd   = 1'b0;
            n_clr_addr = r_clr_addr + t_slot'(1);
            if (r_clr_addr == t_slot'(POOL_DEPTH - 1)) begin
                n_clr = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_size      = sz;
                    n_half      = h;
                    n_mask      = ~(t_half_word'('1) << h);
                    n_from_ring = 1'b0;
                    n_slot      = '0;
                    case (i_mode)
                        MODE_GET: begin
                            if (r_used >= sz) begin
                                n_done   = 1'b1;
                                n_status = ST_NONE;
                            end else if (r_fill < sz) begin
                                if (r_seed_nz) begin
                                    n_l     = xs[HALF_W-1:0] & n_mask;
                                    n_r     = x[HALF_W-1:0] & n_mask;
                                    n_round = '0;
                                    n_state = S_PA;
                                end else begin
                                    n_cand  = x;
                                    n_state = S_LW;
                                end
                            end else if (r_rcount == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_NONE;
                            end else begin
                                n_state = S_RW;
                            end
                        end
                        MODE_MARK: begin
                            n_done = 1'b1;
                            if (t_count'(i_slot_index) >= sz) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_status = ST_OK;
                                lease_we = 1'b1;
                                lease_wa = i_slot_index;
                                lease_wd = 1'b1;
                                if (r_fill < sz) begin
                                    n_fill = r_fill + t_count'(1);
                                end
                                if (r_used < t_count'(POOL_DEPTH)) begin
                                    n_used = r_used + t_count'(1);
                                end
                            end
                        end
                        MODE_RELEASE: begin
                            n_done = 1'b1;
                            if (t_count'(i_slot_index) >= sz) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_status = ST_OK;
                                lease_we = 1'b1;
                                lease_wa = i_slot_index;
                                lease_wd = 1'b0;
                                ring_we  = 1'b1;
                                if (r_used != '0) begin
                                    n_used = r_used - t_count'(1);
                                end
                                if (r_rcount >= sz) begin
                                    n_rcount = sz;
                                    n_tail   = ring_next(r_tail, sz);
                                end else begin
                                    n_rcount = r_rcount + t_count'(1);
                                end
                                n_head = ring_next(r_head, sz);
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_PA: begin
                n_m     = 32'(v * MIX_A);
                n_state = S_PB;
            end
            S_PB: begin
                n_m     = 32'(vm * MIX_B);
                n_state = S_PC;
            end
            S_PC: begin
                n_r = r_l ^ (vm[HALF_W-1:0] & r_mask);
                n_l = r_r;
                if (r_round == RND_W'(ROUNDS - 1)) begin
                    n_round = '0;
                    n_state = S_PX;
                end else begin
                    n_round = r_round + RND_W'(1);
                    n_state = S_PA;
                end
            end
            S_PX: begin
                x  = (t_slot'(r_l) << r_half) | t_slot'(r_r);
                xs = x >> r_half;
                if (t_count'(x) >= r_size) begin
                    // cycle walking: run the permutation again on the out-of-range value
                    n_l     = xs[HALF_W-1:0] & r_mask;
                    n_r     = x[HALF_W-1:0] & r_mask;
                    n_state = S_PA;
                end else begin
                    n_cand  = x;
                    n_state = S_LW;
                end
            end
            S_LW: begin
                n_state = S_LCHK;
            end
            S_LCHK: begin
                if (!r_lease_q) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_slot   = r_cand;
                    n_state  = S_IDLE;
                end else if (r_from_ring || r_rcount == '0) begin
                    n_done   = 1'b1;
                    n_status = ST_NONE;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_RW;
                end
            end
            S_RW: begin
                n_state = S_RCHK;
            end
            S_RCHK: begin
                n_tail   = ring_next(r_tail, r_size);
                n_rcount = r_rcount - t_count'(1);
                if (t_count'(r_ring_q) < r_size) begin
                    n_cand      = r_ring_q;
                    n_from_ring = 1'b1;
                    n_state     = S_LW;
                end else begin
                    n_done   = 1'b1;
                    n_status = ST_NONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lease_we) begin
            lease_mem[lease_wa] <= lease_wd;
        end
        r_lease_q <= lease_mem[r_cand];
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_head] <= i_slot_index;
        end
        r_ring_q <= ring_mem[r_tail];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pool_size <= t_count'(POOL_DEPTH);
            r_seed_nz   <= 1'b0;
            r_round     <= '0;
            r_fill      <= '0;
            r_used      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_rcount    <= '0;
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pool_size <= n_pool_size;
            r_seed_nz   <= n_seed_nz;
            r_round     <= n_round;
            r_fill      <= n_fill;
            r_used      <= n_used;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_rcount    <= n_rcount;
            r_clr       <= n_clr;
            r_clr_addr  <= n_clr_addr;
            r_done      <= n_done;
        end
        r_size      <= n_size;
        r_half      <= n_half;
        r_mask      <= n_mask;
        r_l         <= n_l;
        r_r         <= n_r;
        r_m         <= n_m;
        r_cand      <= n_cand;
        r_from_ring <= n_from_ring;
        r_status    <= n_status;
        r_slot      <= n_slot;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_slot_out     = r_slot;
    assign o_leased_count = r_used;

    `LIA_ASSERT_IMP(a_used_cap, 1'b1, r_used <= t_count'(POOL_DEPTH), "used count above pool depth")
    `LIA_ASSERT_IMP(a_ring_cap, 1'b1, r_rcount <= t_count'(POOL_DEPTH), "ring count above pool depth")
    `LIA_ASSERT_NXT(a_quick_done, accept && i_mode != MODE_GET, o_done, "mark or release result late")
    `LIA_ASSERT_IMP(a_range_slot, o_done && o_status == ST_RANGE, o_slot_out == '0, "range error with slot")
    `LIA_ASSERT_IMP(a_clr_busy, r_clr, busy && !o_done, "item taken during bitmap clear")

endmodule
